>>> design/button_debounce_long_press_core_defines.svh
// ----------------------------------------------------------------------------
// Button debounce assertion macros
// Shared assertion shorthands for the checker of the button debounce core.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define BDLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define BDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce package
// Types, constants and codes shared by the button debounce core.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

    localparam int NUM_BUTTONS = 6;
    localparam int TIME_BITS   = 48;
    localparam int KEY_BITS    = 3;
    localparam int SEQ_BITS    = 32;
    localparam int POLL_BITS   = 4;
    localparam int THR_BITS    = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int IDX_BITS    = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    localparam logic [IDX_BITS-1:0]    LAST_IDX = IDX_BITS'(NUM_BUTTONS - 1);
    localparam logic [IDX_BITS-1:0]    BACK_KEY = IDX_BITS'(5);

    localparam logic [NUM_BUTTONS-1:0] MASK_RESET       = '1;
    localparam logic [POLL_BITS-1:0]   DEBOUNCE_RESET   = POLL_BITS'(2);
    localparam logic [THR_BITS-1:0]    LONG_PRESS_RESET = THR_BITS'(2500000);

    typedef enum logic [1:0] {
        EV_PRESS    = 2'd0,
        EV_SHORT    = 2'd1,
        EV_RELEASE  = 2'd2,
        EV_SHUTDOWN = 2'd3
    } t_event;

    typedef enum logic {
        KIND_POLL  = 1'b0,
        KIND_CHECK = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ACTIVE_LOW_MASK = 2'd0,
        CFG_DEBOUNCE_COUNT  = 2'd1,
        CFG_LONG_PRESS_US   = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TRIPLE,
        ST_CHECK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] active_low_mask;
        logic [POLL_BITS-1:0]   debounce_count;
        logic [THR_BITS-1:0]    long_press_us;
    } t_cfg;

    typedef struct packed {
        t_kind                  kind;
        logic [NUM_BUTTONS-1:0] raw_levels;
        logic [TIME_BITS-1:0]   now_us;
    } t_in_item;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        t_event              event_type;
        logic [SEQ_BITS-1:0] sequence_number;
        logic                last;
    } t_out_item;

    // Request from the sequencer to the output stage.
    typedef struct packed {
        logic                push;
        logic                flush;
        logic [KEY_BITS-1:0] key;
        t_event              event_type;
        logic [SEQ_BITS-1:0] seq;
    } t_emit_req;

endpackage

`default_nettype wire

>>> design/bdlp_cfg.sv
// ----------------------------------------------------------------------------
// Button debounce configuration registers
// Holds the polarity mask, debounce count and long press threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bdlp_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [bdlp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output bdlp_pkg::t_cfg                           o_cfg
);

    bdlp_pkg::t_cfg r_cfg;

    // Writes are always accepted, so the port never stalls.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low_mask <= bdlp_pkg::MASK_RESET;
            r_cfg.debounce_count  <= bdlp_pkg::DEBOUNCE_RESET;
            r_cfg.long_press_us   <= bdlp_pkg::LONG_PRESS_RESET;
        end else if (i_cfg_valid) begin
            unique case (bdlp_pkg::t_cfg_index'(i_cfg_index))
                bdlp_pkg::CFG_ACTIVE_LOW_MASK: begin
                    r_cfg.active_low_mask <= i_cfg_data[bdlp_pkg::NUM_BUTTONS-1:0];
                end
                bdlp_pkg::CFG_DEBOUNCE_COUNT: begin
                    r_cfg.debounce_count <= i_cfg_data[bdlp_pkg::POLL_BITS-1:0];
                end
                bdlp_pkg::CFG_LONG_PRESS_US: begin
                    r_cfg.long_press_us <= i_cfg_data[bdlp_pkg::THR_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/bdlp_hold.sv
// ----------------------------------------------------------------------------
// Button debounce hold time unit
// Shared subtract and compare that classifies a hold as short or long.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_hold (
    input  wire logic [bdlp_pkg::TIME_BITS-1:0] i_now,
    input  wire logic [bdlp_pkg::TIME_BITS-1:0] i_start,
    input  wire logic [bdlp_pkg::THR_BITS-1:0]  i_threshold,
    output logic                                o_short
);

    logic [bdlp_pkg::TIME_BITS-1:0] w_dur;

    // The time base wraps, so the difference is taken modulo its width.
    assign w_dur   = i_now - i_start;
    assign o_short = w_dur < bdlp_pkg::TIME_BITS'(i_threshold);

endmodule

`default_nettype wire

>>> design/bdlp_ostage.sv
// ----------------------------------------------------------------------------
// Button debounce output stage
// Holds one result back so that the final result of a request can be marked.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_ostage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bdlp_pkg::t_emit_req i_req,
    output logic                     o_req_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output bdlp_pkg::t_out_item      o_out_data
);

    logic                r_pend_valid;
    logic                n_pend_valid;
    bdlp_pkg::t_out_item r_pend;
    bdlp_pkg::t_out_item n_pend;
    logic                r_out_valid;
    logic                n_out_valid;
    bdlp_pkg::t_out_item r_out;
    bdlp_pkg::t_out_item n_out;
    logic                w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_req_ready = !r_pend_valid || w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_req.push && o_req_ready) begin
            // A newer result exists, so the held one cannot be the last.
            if (r_pend_valid) begin
                n_out       = r_pend;
                n_out.last  = 1'b0;
                n_out_valid = 1'b1;
            end
            n_pend_valid           = 1'b1;
            n_pend.key             = i_req.key;
            n_pend.event_type      = i_req.event_type;
            n_pend.sequence_number = i_req.seq;
            n_pend.last            = 1'b0;
        end else if (i_req.flush && o_req_ready && r_pend_valid) begin
            n_out        = r_pend;
            n_out.last   = 1'b1;
            n_out_valid  = 1'b1;
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

>>> design/button_debounce_long_press_core.sv
// ----------------------------------------------------------------------------
// Button debounce and long press core
// Debounces six buttons, synthesises short clicks and requests shutdown.
// ----------------------------------------------------------------------------
// A poll request carries the raw pin levels and a microsecond timestamp; a
// check request asks whether the back button has been held past the long
// press threshold. The block takes one request at a time. A small sequencer
// visits the buttons in the order up, down, left, right, ok, back, one per
// clock while no result waits for the output stage and no short click is
// inserted, and shares a single subtract-and-compare unit for every hold
// time. A poll is accepted in the idle state, scans each button in turn,
// emits the press, short and release of each synthesised short click, and
// closes the request with a flush; a check looks at back and then flushes.
// Each result must pass a one-entry hold register and the output register,
// so a stalled consumer holds up the sequencer. The result held back is
// what lets the block mark the final result of a request with last.
// Configuration writes take effect in the cycle after they are accepted and
// should only be made while the block is idle. After reset every button is
// released, no button has a press time and the sequence counter is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire bdlp_pkg::t_in_item                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output bdlp_pkg::t_out_item                      o_out_data,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bdlp_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [bdlp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int NB = bdlp_pkg::NUM_BUTTONS;
    localparam int IB = bdlp_pkg::IDX_BITS;
    localparam int PB = bdlp_pkg::POLL_BITS;
    localparam int TB = bdlp_pkg::TIME_BITS;
    localparam int SB = bdlp_pkg::SEQ_BITS;
    localparam int KB = bdlp_pkg::KEY_BITS;
    localparam logic [1:0] SUB_LAST = 2'd2;

    bdlp_pkg::t_cfg      w_cfg;
    bdlp_pkg::t_emit_req w_req;
    logic                w_req_ready;
    logic                w_short;

    // Sequencer and button state.
    bdlp_pkg::t_state    r_state;
    bdlp_pkg::t_state    n_state;
    logic [IB-1:0]       r_idx;
    logic [IB-1:0]       n_idx;
    logic [1:0]          r_sub;
    logic [1:0]          n_sub;
    bdlp_pkg::t_in_item  r_item;
    bdlp_pkg::t_in_item  n_item;
    logic [NB-1:0]       r_raw;
    logic [NB-1:0]       n_raw;
    logic [NB-1:0]       r_deb;
    logic [NB-1:0]       n_deb;
    logic [PB-1:0]       r_stable [NB];
    logic [PB-1:0]       n_stable [NB];
    logic [TB-1:0]       r_start  [NB];
    logic [TB-1:0]       n_start  [NB];
    logic [SB-1:0]       r_seq;
    logic [SB-1:0]       n_seq;

    // Debounce step for the button under the scan pointer.
    logic                w_pressed;
    logic                w_raw_next;
    logic [PB-1:0]       w_stable_next;
    logic                w_fire;
    logic [IB-1:0]       w_hold_idx;

    // Where the scan goes once the current button is finished.
    bdlp_pkg::t_state    w_adv_state;
    logic [IB-1:0]       w_adv_idx;

    bdlp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // The check request always looks at back; a poll looks at the scanned button.
    assign w_hold_idx = (r_state == bdlp_pkg::ST_CHECK) ? bdlp_pkg::BACK_KEY : r_idx;

    bdlp_hold u_hold (
        .i_now       (r_item.now_us),
        .i_start     (r_start[w_hold_idx]),
        .i_threshold (w_cfg.long_press_us),
        .o_short     (w_short)
    );

    bdlp_ostage u_ostage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .o_req_ready (w_req_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always_comb begin
        w_pressed = r_item.raw_levels[r_idx] ^ w_cfg.active_low_mask[r_idx];
        if (w_pressed == r_raw[r_idx]) begin
            w_raw_next    = r_raw[r_idx];
            w_stable_next = (r_stable[r_idx] < w_cfg.debounce_count)
                          ? PB'(r_stable[r_idx] + 1'b1) : r_stable[r_idx];
        end else begin
            w_raw_next    = w_pressed;
            w_stable_next = PB'(1);
        end
        // A qualified level that differs from the debounced one is an event.
        w_fire = (w_stable_next >= w_cfg.debounce_count) && (r_deb[r_idx] != w_raw_next);
    end

    always_comb begin
        if (r_idx == bdlp_pkg::LAST_IDX) begin
            w_adv_state = bdlp_pkg::ST_FLUSH;
            w_adv_idx   = r_idx;
        end else begin
            w_adv_state = bdlp_pkg::ST_SCAN;
            w_adv_idx   = IB'(r_idx + 1'b1);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_sub    = r_sub;
        n_item   = r_item;
        n_raw    = r_raw;
        n_deb    = r_deb;
        n_stable = r_stable;
        n_start  = r_start;
        n_seq    = r_seq;

        w_req.push       = 1'b0;
        w_req.flush      = 1'b0;
        w_req.key        = KB'(r_idx);
        w_req.event_type = bdlp_pkg::EV_PRESS;
        w_req.seq        = SB'(r_seq + 1'b1);

        o_in_ready = 1'b0;

        unique case (r_state)
            bdlp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item = i_in_data;
                    n_idx  = '0;
                    n_state = (i_in_data.kind == bdlp_pkg::KIND_CHECK)
                            ? bdlp_pkg::ST_CHECK : bdlp_pkg::ST_SCAN;
                end
            end

            bdlp_pkg::ST_SCAN: begin
                if (!w_fire) begin
                    n_raw[r_idx]    = w_raw_next;
                    n_stable[r_idx] = w_stable_next;
                    n_state         = w_adv_state;
                    n_idx           = w_adv_idx;
                end else begin
                    // Nothing is committed until the output stage takes the result.
                    w_req.push       = 1'b1;
                    w_req.event_type = w_raw_next ? bdlp_pkg::EV_PRESS
                                                  : bdlp_pkg::EV_RELEASE;
                    if (w_req_ready) begin
                        n_raw[r_idx]    = w_raw_next;
                        n_stable[r_idx] = w_stable_next;
                        n_deb[r_idx]    = w_raw_next;
                        if (w_raw_next) begin
                            n_start[r_idx] = r_item.now_us;
                            n_seq          = SB'(r_seq + 1'b1);
                            n_state        = w_adv_state;
                            n_idx          = w_adv_idx;
                        end else begin
                            n_start[r_idx] = '0;
                            if (w_short) begin
                                // The synthesised click takes the following number.
                                n_seq   = SB'(r_seq + 2'd2);
                                n_sub   = '0;
                                n_state = bdlp_pkg::ST_TRIPLE;
                            end else begin
                                n_seq   = SB'(r_seq + 1'b1);
                                n_state = w_adv_state;
                                n_idx   = w_adv_idx;
                            end
                        end
                    end
                end
            end

            bdlp_pkg::ST_TRIPLE: begin
                w_req.push = 1'b1;
                w_req.seq  = r_seq;
                case (r_sub)
                    2'd0:    w_req.event_type = bdlp_pkg::EV_PRESS;
                    2'd1:    w_req.event_type = bdlp_pkg::EV_SHORT;
                    default: w_req.event_type = bdlp_pkg::EV_RELEASE;
                endcase
                if (w_req_ready) begin
                    if (r_sub == SUB_LAST) begin
                        n_state = w_adv_state;
                        n_idx   = w_adv_idx;
                    end else begin
                        n_sub = 2'(r_sub + 1'b1);
                    end
                end
            end

            bdlp_pkg::ST_CHECK: begin
                w_req.key        = KB'(bdlp_pkg::BACK_KEY);
                w_req.event_type = bdlp_pkg::EV_SHUTDOWN;
                w_req.seq        = r_seq;
                if (r_deb[bdlp_pkg::BACK_KEY] && !w_short) begin
                    w_req.push = 1'b1;
                    if (w_req_ready) begin
                        n_state = bdlp_pkg::ST_FLUSH;
                    end
                end else begin
                    n_state = bdlp_pkg::ST_FLUSH;
                end
            end

            bdlp_pkg::ST_FLUSH: begin
                // Release the held result, marked as the last of this request.
                w_req.flush = 1'b1;
                if (w_req_ready) begin
                    n_state = bdlp_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = bdlp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdlp_pkg::ST_IDLE;
            r_idx   <= '0;
            r_sub   <= '0;
            r_raw   <= '0;
            r_deb   <= '0;
            r_seq   <= '0;
            for (int i = 0; i < NB; i++) begin
                r_stable[i] <= bdlp_pkg::DEBOUNCE_RESET;
                r_start[i]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_sub    <= n_sub;
            r_raw    <= n_raw;
            r_deb    <= n_deb;
            r_seq    <= n_seq;
            r_stable <= n_stable;
            r_start  <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

`default_nettype wire

>>> design/bdlp_checker.sv
// ----------------------------------------------------------------------------
// Button debounce checker
// Port-level assertions for the button debounce core, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_long_press_core_defines.svh"

module bdlp_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire bdlp_pkg::t_out_item i_out_data
);

    // A stalled result must hold still.
    `BDLP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "result changed while stalled")

    // The block works on one request at a time.
    `BDLP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "request accepted while busy")

    // While a request still has results to come, no new request is taken.
    `BDLP_ASSERT_NOW(a_no_accept_mid_request, i_clk, i_rst_n, i_out_valid && !i_out_data.last, !i_in_ready, "ready before the last result")

    // A shutdown request is always for back and always stands alone.
    `BDLP_ASSERT_NOW(a_shutdown_form, i_clk, i_rst_n, i_out_valid && (i_out_data.event_type == bdlp_pkg::EV_SHUTDOWN), (i_out_data.key == bdlp_pkg::KEY_BITS'(bdlp_pkg::BACK_KEY)) && i_out_data.last, "malformed shutdown result")

    // A short event is always followed by its release.
    `BDLP_ASSERT_NOW(a_short_not_last, i_clk, i_rst_n, i_out_valid && (i_out_data.event_type == bdlp_pkg::EV_SHORT), !i_out_data.last, "short event marked last")

endmodule

bind button_debounce_long_press_core bdlp_checker u_bdlp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

`default_nettype wire

>>> tb/sv/button_debounce_long_press_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button debounce and long press core testbench
// Sends poll and check requests with a moving microsecond clock, predicts the
// press, short, release and shutdown events, and compares every result.
// ----------------------------------------------------------------------------
module button_debounce_long_press_core_tb;

    localparam int NUM_BUTTONS   = bdlp_pkg::NUM_BUTTONS;
    localparam int TIME_BITS     = bdlp_pkg::TIME_BITS;
    localparam int KEY_BITS      = bdlp_pkg::KEY_BITS;
    localparam int SEQ_BITS      = bdlp_pkg::SEQ_BITS;
    localparam int POLL_BITS     = bdlp_pkg::POLL_BITS;
    localparam int THR_BITS      = bdlp_pkg::THR_BITS;
    localparam int CFG_IDX_BITS  = bdlp_pkg::CFG_IDX_BITS;
    localparam int CFG_DATA_BITS = bdlp_pkg::CFG_DATA_BITS;

    // One cycle is 2 ns. The limit lies far beyond the slowest correct run.
    localparam int TIMEOUT_NS    = 2_000_000;
    // The block may still be closing a request that produced no result when
    // the last expected result has come. This many cycles covers that tail.
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_PRINTED   = 30;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    bdlp_pkg::t_in_item       in_data;
    logic                     out_valid;
    logic                     out_ready;
    bdlp_pkg::t_out_item      out_data;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    button_debounce_long_press_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Our own copy of the configuration and the debouncer state. It is kept
    // in step with the block by updating it at the very edge at which a
    // register write or a request is accepted.
    // ------------------------------------------------------------------------
    logic [NUM_BUTTONS-1:0] cfg_mask;
    logic [POLL_BITS-1:0]   cfg_debounce;
    logic [THR_BITS-1:0]    cfg_hold_limit;

    logic [NUM_BUTTONS-1:0] sampled_pressed;
    logic [NUM_BUTTONS-1:0] settled_pressed;
    logic [POLL_BITS-1:0]   match_polls [NUM_BUTTONS];
    logic [TIME_BITS-1:0]   press_time  [NUM_BUTTONS];
    logic [SEQ_BITS-1:0]    event_seq;

    // Events still owed by the block, oldest first.
    bdlp_pkg::t_out_item pending_events[$];

    // The microsecond clock that the stimulus carries in each request.
    logic [TIME_BITS-1:0] clock_us;

    // Idling controls. The sender idles before a request and the receiver
    // withholds ready, each in random bursts, with a chance set per phase so
    // that some stretches have no idling at all.
    logic idle_en;
    int   send_gap_pct;
    int   drain_stall_pct;

    int mismatches;
    int requests_sent;
    int polls_sent;
    int checks_sent;
    int results_checked;
    int shorts_predicted;
    int shutdowns_predicted;
    int register_writes;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses results.
    initial begin
        #TIMEOUT_NS;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Mismatch reporting: every failure passes through here.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("tb: mismatch at %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Event prediction.
    // ------------------------------------------------------------------------
    function automatic bdlp_pkg::t_out_item make_event(input logic [KEY_BITS-1:0] key,
                                                       input bdlp_pkg::t_event ev_kind,
                                                       input logic [SEQ_BITS-1:0] seq);
        bdlp_pkg::t_out_item ev;
        ev.key             = key;
        ev.event_type      = ev_kind;
        ev.sequence_number = seq;
        ev.last            = 1'b0;
        return ev;
    endfunction

    // Works out the events that one accepted request causes and queues them.
    // A check only looks at the back button; a poll runs each button through
    // its debouncer in key order, so the events come out in that order too.
    function automatic void predict_request(input bdlp_pkg::t_in_item req);
        bdlp_pkg::t_out_item  burst[$];
        logic [TIME_BITS-1:0] held;
        logic                 pressed;
        logic [KEY_BITS-1:0]  key;

        if (req.kind == bdlp_pkg::KIND_CHECK) begin
            held = req.now_us - press_time[bdlp_pkg::BACK_KEY];
            if (settled_pressed[bdlp_pkg::BACK_KEY] &&
                held >= TIME_BITS'(cfg_hold_limit)) begin
                // A shutdown request reuses the current number; no advance.
                burst.push_back(make_event(KEY_BITS'(bdlp_pkg::BACK_KEY),
                                           bdlp_pkg::EV_SHUTDOWN, event_seq));
                shutdowns_predicted++;
            end
        end else begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                key     = KEY_BITS'(b);
                pressed = req.raw_levels[b] ^ cfg_mask[b];
                if (pressed == sampled_pressed[b]) begin
                    if (match_polls[b] < cfg_debounce)
                        match_polls[b] = match_polls[b] + 1'b1;
                end else begin
                    sampled_pressed[b] = pressed;
                    match_polls[b]     = POLL_BITS'(1);
                end
                if (match_polls[b] >= cfg_debounce &&
                    settled_pressed[b] != sampled_pressed[b]) begin
                    settled_pressed[b] = sampled_pressed[b];
                    if (settled_pressed[b]) begin
                        press_time[b] = req.now_us;
                        event_seq     = event_seq + 1'b1;
                        burst.push_back(make_event(key, bdlp_pkg::EV_PRESS, event_seq));
                    end else begin
                        held          = req.now_us - press_time[b];
                        press_time[b] = '0;
                        event_seq     = event_seq + 1'b1;
                        burst.push_back(make_event(key, bdlp_pkg::EV_RELEASE, event_seq));
                        // A short hold is followed by a synthesised click:
                        // press, short and release under one new number.
                        if (held < TIME_BITS'(cfg_hold_limit)) begin
                            event_seq = event_seq + 1'b1;
                            burst.push_back(make_event(key, bdlp_pkg::EV_PRESS,
                                                       event_seq));
                            burst.push_back(make_event(key, bdlp_pkg::EV_SHORT,
                                                       event_seq));
                            burst.push_back(make_event(key, bdlp_pkg::EV_RELEASE,
                                                       event_seq));
                            shorts_predicted++;
                        end
                    end
                end
            end
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[k])
            pending_events.push_back(burst[k]);
    endfunction

    // ------------------------------------------------------------------------
    // Result checker. Each accepted result is compared with the oldest
    // expectation, one field at a time.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        bdlp_pkg::t_out_item want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result key %0d type %0d seq %0d",
                                          out_data.key, out_data.event_type,
                                          out_data.sequence_number));
            end else begin
                want = pending_events.pop_front();
                results_checked++;
                if (out_data.key !== want.key)
                    report_mismatch($sformatf("key %0d, expected %0d",
                                              out_data.key, want.key));
                if (out_data.event_type !== want.event_type)
                    report_mismatch($sformatf("event type %0d, expected %0d (key %0d)",
                                              out_data.event_type, want.event_type,
                                              want.key));
                if (out_data.sequence_number !== want.sequence_number)
                    report_mismatch($sformatf("sequence %0d, expected %0d",
                                              out_data.sequence_number,
                                              want.sequence_number));
                if (out_data.last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b (seq %0d)",
                                              out_data.last, want.last,
                                              want.sequence_number));
            end
        end
    end

    // Receiver: ready is withheld in random bursts while idling is enabled.
    initial begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (idle_en && $urandom_range(0, 99) < drain_stall_pct) begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Request and register traffic.
    // ------------------------------------------------------------------------

    // Offers one request and returns at the edge that accepts it. Valid is
    // left high, so back-to-back requests keep it high without a dip.
    task automatic send_request(input bdlp_pkg::t_in_item req);
        if (idle_en && $urandom_range(0, 99) < send_gap_pct) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end else begin
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = req;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_request(req);
        requests_sent++;
    endtask

    task automatic poll_levels(input logic [NUM_BUTTONS-1:0] levels);
        bdlp_pkg::t_in_item req;
        req.kind       = bdlp_pkg::KIND_POLL;
        req.raw_levels = levels;
        req.now_us     = clock_us;
        send_request(req);
        polls_sent++;
    endtask

    // Poll with a set of buttons held, translated to pin levels through the
    // current polarity mask.
    task automatic poll_pressed(input logic [NUM_BUTTONS-1:0] pressed);
        poll_levels(pressed ^ cfg_mask);
    endtask

    // The pin levels of a check are ignored by the block, so they are random.
    task automatic check_tick();
        bdlp_pkg::t_in_item req;
        req.kind       = bdlp_pkg::KIND_CHECK;
        req.raw_levels = NUM_BUTTONS'($urandom);
        req.now_us     = clock_us;
        send_request(req);
        checks_sent++;
    endtask

    // Stops sending and waits until every expected result has arrived, then
    // lets the block finish whatever request produced nothing.
    task automatic wait_until_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input bdlp_pkg::t_cfg_index idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            bdlp_pkg::CFG_ACTIVE_LOW_MASK: cfg_mask       = value[NUM_BUTTONS-1:0];
            bdlp_pkg::CFG_DEBOUNCE_COUNT:  cfg_debounce   = value[POLL_BITS-1:0];
            bdlp_pkg::CFG_LONG_PRESS_US:   cfg_hold_limit = value[THR_BITS-1:0];
            default: ;
        endcase
        register_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Registers are only written once the block has gone quiet.
    task automatic apply_settings(input logic [NUM_BUTTONS-1:0] mask,
                                  input logic [POLL_BITS-1:0] debounce,
                                  input logic [THR_BITS-1:0] hold_limit);
        wait_until_drained();
        write_register(bdlp_pkg::CFG_ACTIVE_LOW_MASK, CFG_DATA_BITS'(mask));
        write_register(bdlp_pkg::CFG_DEBOUNCE_COUNT, CFG_DATA_BITS'(debounce));
        write_register(bdlp_pkg::CFG_LONG_PRESS_US, CFG_DATA_BITS'(hold_limit));
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reset values: active-low pins, two matching polls, 2.5 s threshold.
    // Covers a bounce-free click on up, a back button held past the
    // threshold across the wrap of the microsecond clock, and checks both
    // before and after the threshold.
    task automatic test_reset_settings();
        clock_us = 48'h0000_0100_0000;
        poll_pressed(6'b000000);
        poll_pressed(6'b000001);
        poll_pressed(6'b000001);
        clock_us += 48'd1000;
        poll_pressed(6'b000000);
        poll_pressed(6'b000000);
        // Back goes down so that the threshold is reached at an all-ones
        // timestamp, and the release comes just after the clock has wrapped.
        clock_us = '1 - TIME_BITS'(bdlp_pkg::LONG_PRESS_RESET);
        poll_pressed(6'b100000);
        poll_pressed(6'b100000);
        clock_us += TIME_BITS'(bdlp_pkg::LONG_PRESS_RESET) - 48'd1;
        check_tick();
        clock_us += 48'd1;
        check_tick();
        clock_us += 48'd5;
        poll_pressed(6'b000000);
        poll_pressed(6'b000000);
        check_tick();
    endtask

    // Active-high pins, single-poll debounce and a threshold of one: all six
    // buttons pressed and released in the same microsecond give the largest
    // burst of results, then a hold of exactly one microsecond is long.
    task automatic test_all_buttons();
        apply_settings(6'b000000, 4'd1, 32'd1);
        poll_pressed(6'b111111);
        poll_pressed(6'b000000);
        poll_pressed(6'b111111);
        clock_us += 48'd1;
        poll_pressed(6'b000000);
        poll_pressed(6'b100000);
        clock_us += 48'd1;
        check_tick();
    endtask

    // A debounce count of zero takes every poll at once. With the largest
    // threshold, a hold one below it is short and a hold beyond 32 bits of
    // microseconds is long.
    task automatic test_hold_limits();
        apply_settings(6'b110011, 4'd0, 32'hFFFF_FFFF);
        poll_pressed(6'b000001);
        clock_us += 48'h0000_FFFF_FFFE;
        poll_pressed(6'b000000);
        poll_pressed(6'b000010);
        clock_us += 48'h0001_0000_0000;
        poll_pressed(6'b000000);
        poll_pressed(6'b000000);
        check_tick();
    endtask

    // Random phase. Most of the traffic is well-formed button sequences:
    // a new set of held buttons kept for long enough to debounce, with
    // timestamps that move on a scale matched to the threshold. Mixed in are
    // single noisy polls, sequences cut short by one poll, check
    // requests and occasional huge jumps of the clock.
    task automatic test_random_phase(input logic [NUM_BUTTONS-1:0] mask,
                                     input logic [POLL_BITS-1:0] debounce,
                                     input logic [THR_BITS-1:0] hold_limit,
                                     input int poll_target,
                                     input int gap_pct,
                                     input int stall_pct);
        logic [NUM_BUTTONS-1:0] target;
        logic [31:0]            step_span;
        int                     start_polls;
        int                     hold_polls;

        apply_settings(mask, debounce, hold_limit);
        send_gap_pct    = gap_pct;
        drain_stall_pct = stall_pct;
        step_span       = (cfg_hold_limit >> 3) == 0 ? 32'd1 : cfg_hold_limit >> 3;
        target          = settled_pressed;
        start_polls     = polls_sent;
        while (polls_sent - start_polls < poll_target) begin
            case ($urandom_range(0, 3))
                0: target ^= NUM_BUTTONS'(1) << $urandom_range(0, NUM_BUTTONS - 1);
                1: target = NUM_BUTTONS'($urandom);
                2: target ^= (NUM_BUTTONS'(1) << $urandom_range(0, NUM_BUTTONS - 1)) |
                             (NUM_BUTTONS'(1) << $urandom_range(0, NUM_BUTTONS - 1));
                default: ;
            endcase
            if ($urandom_range(0, 4) == 0)
                poll_levels(NUM_BUTTONS'($urandom));
            hold_polls = (cfg_debounce == 0 ? 1 : int'(cfg_debounce)) +
                         $urandom_range(0, 2);
            // Now and then the sequence is cut short by one poll.
            if ($urandom_range(0, 7) == 0 && hold_polls > 1)
                hold_polls--;
            repeat (hold_polls) begin
                if ($urandom_range(0, 19) == 0)
                    clock_us += {32'($urandom), 16'($urandom)};
                else
                    clock_us += TIME_BITS'($urandom_range(0, step_span));
                if ($urandom_range(0, 3) == 0)
                    check_tick();
                poll_pressed(target);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        rst_n               = 1'b0;
        in_valid            = 1'b0;
        in_data             = '0;
        cfg_valid           = 1'b0;
        cfg_index           = bdlp_pkg::CFG_ACTIVE_LOW_MASK;
        cfg_data            = '0;
        idle_en             = 1'b0;
        send_gap_pct        = 0;
        drain_stall_pct     = 0;
        mismatches          = 0;
        requests_sent       = 0;
        polls_sent          = 0;
        checks_sent         = 0;
        results_checked     = 0;
        shorts_predicted    = 0;
        shutdowns_predicted = 0;
        register_writes     = 0;
        clock_us            = '0;

        // State after reset: every button released, no press times, the
        // counter at zero and the registers at their reset values.
        cfg_mask        = bdlp_pkg::MASK_RESET;
        cfg_debounce    = bdlp_pkg::DEBOUNCE_RESET;
        cfg_hold_limit  = bdlp_pkg::LONG_PRESS_RESET;
        sampled_pressed = '0;
        settled_pressed = '0;
        event_seq       = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            match_polls[b] = bdlp_pkg::DEBOUNCE_RESET;
            press_time[b]  = '0;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The directed tests run with light idling on both sides.
        idle_en         = 1'b1;
        send_gap_pct    = 15;
        drain_stall_pct = 10;
        test_reset_settings();
        test_all_buttons();
        test_hold_limits();

        // Random phases, ending on a stretch with no idling at all.
        test_random_phase(NUM_BUTTONS'($urandom), 4'($urandom_range(1, 4)),
                          32'($urandom_range(100, 20000)), 30, 20, 5);
        test_random_phase(6'b111111, 4'd15, bdlp_pkg::LONG_PRESS_RESET, 55, 10, 15);
        test_random_phase(6'b000000, 4'd0, 32'd1, 30, 0, 0);
        test_random_phase(NUM_BUTTONS'($urandom), 4'd2, 32'hFFFF_FFFF, 30, 30, 8);
        idle_en = 1'b0;
        test_random_phase(NUM_BUTTONS'($urandom), 4'($urandom_range(1, 3)),
                          32'($urandom_range(1, 5000)), 30, 0, 0);

        wait_until_drained();

        $display("tb: %0d requests sent (%0d polls, %0d checks), %0d register writes",
                 requests_sent, polls_sent, checks_sent, register_writes);
        $display("tb: %0d results checked, %0d short clicks, %0d shutdown requests",
                 results_checked, shorts_predicted, shutdowns_predicted);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
